>>> sv/scis_pkg.sv
`default_nettype none

package scis_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_READY_TRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_ARGUMENT  = 1'b1;

	localparam logic [7:0]  MAX_READY_TRIES_RST = 8'd50;
	localparam logic [31:0] READY_ARGUMENT_RST  = 32'h40ff8000;

	// operation codes on the status channel
	localparam logic OP_START    = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	// response patterns
	localparam logic [31:0] OCR_READY_V1  = 32'h80ff8000;
	localparam logic [31:0] OCR_READY_V2  = 32'hc0ff8000;
	localparam logic [3:0]  CUR_STATE_IDENT = 4'd2;
	localparam logic [3:0]  CUR_STATE_STBY  = 4'd3;

	// command numbers and fixed arguments
	localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
	localparam logic [5:0] CMD_ALL_CID     = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
	localparam logic [5:0] ACMD_BUS_WIDTH  = 6'd6;
	localparam logic [5:0] CMD_SELECT      = 6'd7;
	localparam logic [5:0] CMD_IF_COND     = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
	localparam logic [5:0] ACMD_SEND_OCR   = 6'd41;
	localparam logic [5:0] CMD_APP         = 6'd55;
	localparam logic [31:0] IF_COND_ARG    = 32'h000001aa;
	localparam logic [31:0] BUS_4BIT_ARG   = 32'h00000002;

	localparam logic [1:0] VER_UNKNOWN = 2'd0;
	localparam logic [1:0] VER_SD_V1   = 2'd1;
	localparam logic [1:0] VER_SD_V2   = 2'd2;

	// classified status item, as held in the queue
	typedef struct packed {
		logic        op;
		logic        failed;
		logic        ocr_v1;
		logic        ocr_v2;
		logic        st_ident;
		logic        st_stby;
		logic [15:0] rca;
		logic [32:0] csd_blocks;
		logic        csd_bad;
	} entry_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	typedef struct packed {
		logic        cmd_valid;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_argument;
		logic        expect_response;
		logic        long_response;
		logic        delay_first;
		logic        init_done;
		logic        init_failed;
		logic [1:0]  card_version;
		logic [15:0] card_address;
		logic [32:0] block_count;
		logic        capacity_error;
	} result_t;

endpackage

`default_nettype wire

>>> sv/scis_if.sv
`default_nettype none

interface scis_status_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic        response_seen;
	logic        timed_out;
	logic        crc_failed;
	logic        sent_done;
	logic [31:0] resp_word0;
	logic [31:0] resp_word1;
	logic [31:0] resp_word2;
	logic [31:0] resp_word3;

	modport source (output valid, operation, response_seen, timed_out, crc_failed,
		sent_done, resp_word0, resp_word1, resp_word2, resp_word3, input ready);
	modport sink (input valid, operation, response_seen, timed_out, crc_failed,
		sent_done, resp_word0, resp_word1, resp_word2, resp_word3, output ready);
endinterface

interface scis_command_if;
	logic        valid;
	logic        ready;
	logic        cmd_valid;
	logic [5:0]  cmd_index;
	logic [31:0] cmd_argument;
	logic        expect_response;
	logic        long_response;
	logic        delay_first;
	logic        init_done;
	logic        init_failed;
	logic [1:0]  card_version;
	logic [15:0] card_address;
	logic [32:0] block_count;
	logic        capacity_error;

	modport source (output valid, cmd_valid, cmd_index, cmd_argument, expect_response,
		long_response, delay_first, init_done, init_failed, card_version, card_address,
		block_count, capacity_error, input ready);
	modport sink (input valid, cmd_valid, cmd_index, cmd_argument, expect_response,
		long_response, delay_first, init_done, init_failed, card_version, card_address,
		block_count, capacity_error, output ready);
endinterface

interface scis_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/scis_front.sv
`default_nettype none

module scis_front (
	scis_status_if.sink      status,
	input  logic             full,
	output logic             push,
	output scis_pkg::entry_t entry
);
	import scis_pkg::*;

	logic [1:0]  csd_struct;
	logic [11:0] m0;
	logic [12:0] m0_p1;
	logic [4:0]  shift_sum;
	logic [21:0] m1;
	logic [22:0] m1_p1;

	assign status.ready = !full;
	assign push         = status.valid && !full;

	assign csd_struct = status.resp_word0[31:30];
	assign m0         = {status.resp_word1[9:0], status.resp_word2[31:30]};
	assign m0_p1      = {1'b0, m0} + 13'd1;
	assign shift_sum  = {2'b00, status.resp_word2[17:15]} + {1'b0, status.resp_word1[19:16]};
	assign m1         = {status.resp_word1[5:0], status.resp_word2[31:16]};
	assign m1_p1      = {1'b0, m1} + 23'd1;

	always_comb begin
		entry.op       = status.operation;
		entry.failed   = status.timed_out;
		entry.ocr_v1   = status.resp_word0 == OCR_READY_V1;
		entry.ocr_v2   = status.resp_word0 == OCR_READY_V2;
		entry.st_ident = status.resp_word0[12:9] == CUR_STATE_IDENT;
		entry.st_stby  = status.resp_word0[12:9] == CUR_STATE_STBY;
		entry.rca      = status.resp_word0[31:16];
		entry.csd_bad  = 1'b0;
		unique case (csd_struct)
			2'd0: begin
				// count = (C_SIZE+1) * 2^(C_SIZE_MULT+2+READ_BL_LEN) / 512
				if (shift_sum >= 5'd7) begin
					entry.csd_blocks = {20'd0, m0_p1} << (shift_sum - 5'd7);
				end else begin
					entry.csd_blocks = {20'd0, m0_p1} >> (5'd7 - shift_sum);
				end
			end
			2'd1: begin
				entry.csd_blocks = {m1_p1, 10'd0};
			end
			default: begin
				entry.csd_blocks = '0;
				entry.csd_bad    = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/scis_queue.sv
`default_nettype none

module scis_queue #(
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  scis_pkg::entry_t             push_entry,
	input  logic                         pop,
	output scis_pkg::head_t              head,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   level
);
	import scis_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH+1);

	entry_t             slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LVL_W-1:0]   level_q;
	logic               do_pop;

	assign full       = level_q == LVL_W'(DEPTH);
	assign level      = level_q;
	assign head.valid = level_q != '0;
	assign head.entry = slots_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (do_pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/scis_back.sv
`default_nettype none

module scis_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            max_ready_tries,
	input  logic [31:0]           ready_argument,
	input  scis_pkg::head_t       head,
	output logic                  pop,
	scis_command_if.source        command
);
	import scis_pkg::*;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_CMD0    = 4'd1;
	localparam logic [3:0] PH_CMD8    = 4'd2;
	localparam logic [3:0] PH_APP_OCR = 4'd3;
	localparam logic [3:0] PH_ACMD41  = 4'd4;
	localparam logic [3:0] PH_CMD2    = 4'd5;
	localparam logic [3:0] PH_CMD3    = 4'd6;
	localparam logic [3:0] PH_CMD9    = 4'd7;
	localparam logic [3:0] PH_CMD7    = 4'd8;
	localparam logic [3:0] PH_APP_BUS = 4'd9;
	localparam logic [3:0] PH_ACMD6   = 4'd10;
	localparam logic [3:0] PH_DONE    = 4'd11;
	localparam logic [3:0] PH_FAILED  = 4'd12;

	logic [3:0]  phase_q,   phase_d;
	logic [7:0]  tries_q,   tries_d;
	logic [15:0] rca_q,     rca_d;
	logic [1:0]  ver_q,     ver_d;
	logic [32:0] blocks_q,  blocks_d;
	logic        csd_bad_q, csd_bad_d;
	logic        out_valid_q;
	result_t     rsp_q, rsp_d;
	entry_t      e;

	assign e   = head.entry;
	assign pop = head.valid && (!out_valid_q || command.ready);

	always_comb begin
		logic [7:0] limit;
		logic [7:0] tries_inc;
		limit     = (max_ready_tries == 8'd0) ? 8'd1 : max_ready_tries;
		tries_inc = tries_q + 8'd1;

		phase_d   = phase_q;
		tries_d   = tries_q;
		rca_d     = rca_q;
		ver_d     = ver_q;
		blocks_d  = blocks_q;
		csd_bad_d = csd_bad_q;
		rsp_d     = '0;

		if (e.op == OP_START) begin
			phase_d         = PH_CMD0;
			tries_d         = '0;
			rca_d           = '0;
			ver_d           = VER_UNKNOWN;
			blocks_d        = '0;
			csd_bad_d       = 1'b0;
			rsp_d.cmd_valid = 1'b1;
			rsp_d.cmd_index = CMD_GO_IDLE;
		end else begin
			unique case (phase_q)
				PH_CMD0: begin
					phase_d               = PH_CMD8;
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.cmd_index       = CMD_IF_COND;
					rsp_d.cmd_argument    = IF_COND_ARG;
					rsp_d.expect_response = 1'b1;
				end
				PH_CMD8: begin
					phase_d               = PH_APP_OCR;
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.cmd_index       = CMD_APP;
					rsp_d.cmd_argument    = {rca_q, 16'd0};
					rsp_d.expect_response = 1'b1;
				end
				PH_APP_OCR: begin
					phase_d               = PH_ACMD41;
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.cmd_index       = ACMD_SEND_OCR;
					rsp_d.cmd_argument    = ready_argument;
					rsp_d.expect_response = 1'b1;
				end
				PH_ACMD41: begin
					if (!e.failed && e.ocr_v1) begin
						ver_d = VER_SD_V1;
					end else if (!e.failed && e.ocr_v2) begin
						ver_d = VER_SD_V2;
					end
					if (ver_d != VER_UNKNOWN) begin
						phase_d               = PH_CMD2;
						rsp_d.cmd_valid       = 1'b1;
						rsp_d.cmd_index       = CMD_ALL_CID;
						rsp_d.expect_response = 1'b1;
						rsp_d.long_response   = 1'b1;
					end else begin
						tries_d = tries_inc;
						if (tries_inc >= limit) begin
							phase_d = PH_FAILED;
						end else begin
							phase_d               = PH_APP_OCR;
							rsp_d.cmd_valid       = 1'b1;
							rsp_d.cmd_index       = CMD_APP;
							rsp_d.cmd_argument    = {rca_q, 16'd0};
							rsp_d.expect_response = 1'b1;
							rsp_d.delay_first     = 1'b1;
						end
					end
				end
				PH_CMD2: begin
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.expect_response = 1'b1;
					if (e.failed) begin
						rsp_d.cmd_index     = CMD_ALL_CID;
						rsp_d.long_response = 1'b1;
					end else begin
						phase_d         = PH_CMD3;
						rsp_d.cmd_index = CMD_SEND_RCA;
					end
				end
				PH_CMD3: begin
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.expect_response = 1'b1;
					if (e.failed || !e.st_ident) begin
						rsp_d.cmd_index = CMD_SEND_RCA;
					end else begin
						rca_d               = e.rca;
						phase_d             = PH_CMD9;
						rsp_d.cmd_index     = CMD_SEND_CSD;
						rsp_d.cmd_argument  = {e.rca, 16'd0};
						rsp_d.long_response = 1'b1;
					end
				end
				PH_CMD9: begin
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.expect_response = 1'b1;
					rsp_d.cmd_argument    = {rca_q, 16'd0};
					if (e.failed) begin
						rsp_d.cmd_index     = CMD_SEND_CSD;
						rsp_d.long_response = 1'b1;
					end else begin
						blocks_d        = e.csd_blocks;
						csd_bad_d       = e.csd_bad;
						phase_d         = PH_CMD7;
						rsp_d.cmd_index = CMD_SELECT;
					end
				end
				PH_CMD7: begin
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.expect_response = 1'b1;
					rsp_d.cmd_argument    = {rca_q, 16'd0};
					if (e.failed || !e.st_stby) begin
						rsp_d.cmd_index = CMD_SELECT;
					end else begin
						phase_d           = PH_APP_BUS;
						rsp_d.cmd_index   = CMD_APP;
						rsp_d.delay_first = 1'b1;
					end
				end
				PH_APP_BUS: begin
					phase_d               = PH_ACMD6;
					rsp_d.cmd_valid       = 1'b1;
					rsp_d.cmd_index       = ACMD_BUS_WIDTH;
					rsp_d.cmd_argument    = BUS_4BIT_ARG;
					rsp_d.expect_response = 1'b1;
				end
				PH_ACMD6: begin
					if (e.failed) begin
						phase_d               = PH_APP_BUS;
						rsp_d.cmd_valid       = 1'b1;
						rsp_d.cmd_index       = CMD_APP;
						rsp_d.cmd_argument    = {rca_q, 16'd0};
						rsp_d.expect_response = 1'b1;
					end else begin
						phase_d = PH_DONE;
					end
				end
				default: begin
					// idle, done, failed, unused codes: hold
				end
			endcase
		end

		rsp_d.init_done      = phase_d == PH_DONE;
		rsp_d.init_failed    = phase_d == PH_FAILED;
		rsp_d.card_version   = ver_d;
		rsp_d.card_address   = rca_d;
		rsp_d.block_count    = blocks_d;
		rsp_d.capacity_error = csd_bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tries_q     <= '0;
			rca_q       <= '0;
			ver_q       <= VER_UNKNOWN;
			blocks_q    <= '0;
			csd_bad_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				tries_q     <= tries_d;
				rca_q       <= rca_d;
				ver_q       <= ver_d;
				blocks_q    <= blocks_d;
				csd_bad_q   <= csd_bad_d;
				out_valid_q <= 1'b1;
			end else if (command.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= rsp_d;
		end
	end

	assign command.valid           = out_valid_q;
	assign command.cmd_valid       = rsp_q.cmd_valid;
	assign command.cmd_index       = rsp_q.cmd_index;
	assign command.cmd_argument    = rsp_q.cmd_argument;
	assign command.expect_response = rsp_q.expect_response;
	assign command.long_response   = rsp_q.long_response;
	assign command.delay_first     = rsp_q.delay_first;
	assign command.init_done       = rsp_q.init_done;
	assign command.init_failed     = rsp_q.init_failed;
	assign command.card_version    = rsp_q.card_version;
	assign command.card_address    = rsp_q.card_address;
	assign command.block_count     = rsp_q.block_count;
	assign command.capacity_error  = rsp_q.capacity_error;

endmodule

`default_nettype wire

>>> sv/sd_card_init_sequencer_top.sv
// SD card initialization sequencer.
//
// status (sink): one item per controller event. operation = start clears all
//   kept state and issues CMD0; operation = complete closes the outstanding
//   command (timed_out marks it failed) and yields the next one:
//   CMD8, CMD55/ACMD41 until ready or out of tries, CMD2, CMD3, CMD9, CMD7,
//   CMD55, ACMD6.
// command (source): exactly one item per status item, in order. cmd_valid = 0
//   means nothing to issue; init_done / init_failed, card_version,
//   card_address, block_count and capacity_error always show the kept state.
// cfg (sink): always ready; index 0 = max_ready_tries, 1 = ready_argument.
//   Write only while no status item is in flight.
// Path: an accepted status item goes into the queue, then into the back
//   end's output register and onto the command channel. Throughput: one item
//   per cycle while command is not held, set by the single back-end state update.
// Stall: while command is held, status items fill the QUEUE_DEPTH-entry queue
//   and status.ready drops when it is full.
// Reset: queue empty, no command pending, phase idle, registers to defaults.

`default_nettype none

module sd_card_init_sequencer_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	scis_status_if.sink     status,
	scis_command_if.source  command,
	scis_cfg_if.sink        cfg
);
	import scis_pkg::*;

	logic [7:0]  max_tries_q;
	logic [31:0] ready_arg_q;

	logic                             push;
	entry_t                           push_entry;
	logic                             q_full;
	logic                             pop;
	head_t                            head;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

	// config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q <= MAX_READY_TRIES_RST;
			ready_arg_q <= READY_ARGUMENT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_READY_TRIES: max_tries_q <= cfg.data[7:0];
				REG_READY_ARGUMENT:  ready_arg_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// front: accept and classify, CSD decode
	scis_front u_front (
		.status (status),
		.full   (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	scis_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.level      (q_level)
	);

	// back: phase sequencer + output register
	scis_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_ready_tries (max_tries_q),
		.ready_argument  (ready_arg_q),
		.head            (head),
		.pop             (pop),
		.command         (command)
	);

	// queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("queue level above depth");

	// a pop always lands in the output register
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> command.valid)
		else $error("popped item not presented");

	a_done_fail_excl: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid |-> !(command.init_done && command.init_failed))
		else $error("done and failed together");

	a_done_has_version: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid && command.init_done |-> command.card_version != VER_UNKNOWN)
		else $error("done without card version");

	a_bad_csd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid && command.capacity_error |-> command.block_count == '0)
		else $error("bad CSD with nonzero count");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;
	import scis_pkg::*;

	// sequencer position, tracked by the bench alongside the block
	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_CMD0, SEQ_CMD8, SEQ_APP_OCR, SEQ_ACMD41, SEQ_CMD2, SEQ_CMD3,
		SEQ_CMD9, SEQ_CMD7, SEQ_APP_BUS, SEQ_ACMD6, SEQ_DONE, SEQ_FAILED
	} seq_phase_e;

	// CSD_STRUCTURE codes (bits 127..126 of the R2 response)
	localparam logic [1:0] CSD_V1 = 2'd0;
	localparam logic [1:0] CSD_V2 = 2'd1;

	localparam int STUCK_LIMIT  = 2000;  // cycles without any handshake
	localparam int RANDOM_ITEMS = 700;

	// one controller event as offered on the status channel
	typedef struct packed {
		logic        op;
		logic        seen;
		logic        tmo;
		logic        crc;
		logic        sent;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
	} status_item_t;

	logic clk = 1'b0;
	logic arst_n;

	scis_status_if  status_ch();
	scis_command_if command_ch();
	scis_cfg_if     cfg_ch();

	sd_card_init_sequencer_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.status  (status_ch),
		.command (command_ch),
		.cfg     (cfg_ch)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor: bench copy of the sequencer state and registers
	// ---------------------------------------------------------------
	seq_phase_e  seq_phase    = SEQ_IDLE;
	logic [7:0]  try_count    = '0;
	logic [15:0] card_rca     = '0;
	logic [1:0]  card_ver     = VER_UNKNOWN;
	logic [32:0] card_blocks  = '0;
	logic        csd_fault    = 1'b0;
	logic [7:0]  cfg_max_tries = MAX_READY_TRIES_RST;
	logic [31:0] cfg_ocr_arg   = READY_ARGUMENT_RST;

	result_t predicted_cmds[$];   // commands the block still owes, oldest first
	int      mismatch_count = 0;
	int      items_sent = 0;

	// stimulus shaping knobs
	bit quiet_sender = 1'b0;      // no gaps between status items
	bit eager_sink   = 1'b0;      // command side makes no random stalls
	int hold_request = 0;         // long command-side hold, picked up by the sink process

	function automatic result_t cmd_item(input logic [5:0] idx, input logic [31:0] arg,
			input logic rsp, input logic lng, input logic dly);
		result_t r;
		r = '0;
		r.cmd_valid = 1'b1;
		r.cmd_index = idx;
		r.cmd_argument = arg;
		r.expect_response = rsp;
		r.long_response = lng;
		r.delay_first = dly;
		return r;
	endfunction

	// Applies one status item to the bench state, returns the command it yields.
	function automatic result_t advance_card(input status_item_t it);
		result_t     r;
		logic [7:0]  budget;
		logic [11:0] c_size;
		logic [21:0] c_size_hc;
		logic [4:0]  shift;
		logic [32:0] base;
		r = '0;
		if (it.op == OP_START) begin
			// restart from anywhere: everything learned about the card is dropped
			try_count = '0;
			card_rca = '0;
			card_ver = VER_UNKNOWN;
			card_blocks = '0;
			csd_fault = 1'b0;
			seq_phase = SEQ_CMD0;
			r = cmd_item(CMD_GO_IDLE, 32'h0, 1'b0, 1'b0, 1'b0);
		end else begin
			case (seq_phase)
				// CMD0, CMD8 and the app prefix advance whatever the outcome
				SEQ_CMD0: begin
					seq_phase = SEQ_CMD8;
					r = cmd_item(CMD_IF_COND, IF_COND_ARG, 1'b1, 1'b0, 1'b0);
				end
				SEQ_CMD8: begin
					seq_phase = SEQ_APP_OCR;
					r = cmd_item(CMD_APP, {card_rca, 16'h0}, 1'b1, 1'b0, 1'b0);
				end
				SEQ_APP_OCR: begin
					seq_phase = SEQ_ACMD41;
					r = cmd_item(ACMD_SEND_OCR, cfg_ocr_arg, 1'b1, 1'b0, 1'b0);
				end
				SEQ_ACMD41: begin
					// only the two exact ready patterns count, and not on a timeout
					if (!it.tmo && it.w0 == OCR_READY_V1)
						card_ver = VER_SD_V1;
					else if (!it.tmo && it.w0 == OCR_READY_V2)
						card_ver = VER_SD_V2;
					if (card_ver != VER_UNKNOWN) begin
						seq_phase = SEQ_CMD2;
						r = cmd_item(CMD_ALL_CID, 32'h0, 1'b1, 1'b1, 1'b0);
					end else begin
						budget = (cfg_max_tries == 8'd0) ? 8'd1 : cfg_max_tries;
						try_count = try_count + 8'd1;
						if (try_count >= budget) begin
							seq_phase = SEQ_FAILED;
						end else begin
							seq_phase = SEQ_APP_OCR;
							r = cmd_item(CMD_APP, {card_rca, 16'h0}, 1'b1, 1'b0, 1'b1);
						end
					end
				end
				SEQ_CMD2: begin
					if (it.tmo) begin
						r = cmd_item(CMD_ALL_CID, 32'h0, 1'b1, 1'b1, 1'b0);
					end else begin
						seq_phase = SEQ_CMD3;
						r = cmd_item(CMD_SEND_RCA, 32'h0, 1'b1, 1'b0, 1'b0);
					end
				end
				SEQ_CMD3: begin
					// RCA is taken only when the card says it is in ident state
					if (it.tmo || it.w0[12:9] != CUR_STATE_IDENT) begin
						r = cmd_item(CMD_SEND_RCA, 32'h0, 1'b1, 1'b0, 1'b0);
					end else begin
						card_rca = it.w0[31:16];
						seq_phase = SEQ_CMD9;
						r = cmd_item(CMD_SEND_CSD, {card_rca, 16'h0}, 1'b1, 1'b1, 1'b0);
					end
				end
				SEQ_CMD9: begin
					if (it.tmo) begin
						r = cmd_item(CMD_SEND_CSD, {card_rca, 16'h0}, 1'b1, 1'b1, 1'b0);
					end else begin
						if (it.w0[31:30] == CSD_V1) begin
							// C_SIZE spans words 1 and 2; shift may go negative
							c_size = {it.w1[9:0], it.w2[31:30]};
							shift = 5'(it.w2[17:15]) + 5'(it.w1[19:16]);
							base = 33'(c_size) + 33'd1;
							card_blocks = (shift >= 5'd7) ? (base << (shift - 5'd7))
								: (base >> (5'd7 - shift));
							csd_fault = 1'b0;
						end else if (it.w0[31:30] == CSD_V2) begin
							c_size_hc = {it.w1[5:0], it.w2[31:16]};
							card_blocks = (33'(c_size_hc) + 33'd1) << 10;
							csd_fault = 1'b0;
						end else begin
							card_blocks = '0;
							csd_fault = 1'b1;
						end
						seq_phase = SEQ_CMD7;
						r = cmd_item(CMD_SELECT, {card_rca, 16'h0}, 1'b1, 1'b0, 1'b0);
					end
				end
				SEQ_CMD7: begin
					if (it.tmo || it.w0[12:9] != CUR_STATE_STBY) begin
						r = cmd_item(CMD_SELECT, {card_rca, 16'h0}, 1'b1, 1'b0, 1'b0);
					end else begin
						seq_phase = SEQ_APP_BUS;
						r = cmd_item(CMD_APP, {card_rca, 16'h0}, 1'b1, 1'b0, 1'b1);
					end
				end
				SEQ_APP_BUS: begin
					seq_phase = SEQ_ACMD6;
					r = cmd_item(ACMD_BUS_WIDTH, BUS_4BIT_ARG, 1'b1, 1'b0, 1'b0);
				end
				SEQ_ACMD6: begin
					// a failed bus-width switch goes back through CMD55, no delay
					if (it.tmo) begin
						seq_phase = SEQ_APP_BUS;
						r = cmd_item(CMD_APP, {card_rca, 16'h0}, 1'b1, 1'b0, 1'b0);
					end else begin
						seq_phase = SEQ_DONE;
					end
				end
				default: ;  // idle, done, failed: completion ignored
			endcase
		end
		r.init_done = (seq_phase == SEQ_DONE);
		r.init_failed = (seq_phase == SEQ_FAILED);
		r.card_version = card_ver;
		r.card_address = card_rca;
		r.block_count = card_blocks;
		r.capacity_error = csd_fault;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Item builders
	// ---------------------------------------------------------------
	function automatic status_item_t mk_start();
		status_item_t it;
		it = {$urandom, $urandom, $urandom, $urandom, 5'($urandom)};
		it.op = OP_START;
		return it;
	endfunction

	// completion with the given timeout and first word; the rest is noise
	function automatic status_item_t mk_done(input logic tmo, input logic [31:0] w0);
		status_item_t it;
		it = {$urandom, $urandom, $urandom, $urandom, 5'($urandom)};
		it.op = OP_COMPLETE;
		it.tmo = tmo;
		it.w0 = w0;
		return it;
	endfunction

	// completion biased so that sessions usually get past each check
	function automatic status_item_t shaped_completion();
		status_item_t it;
		int pick;
		it = mk_done($urandom_range(99) < 12, $urandom);
		pick = $urandom_range(99);
		case (seq_phase)
			SEQ_ACMD41: begin
				if (pick < 20)
					it.w0 = OCR_READY_V1;
				else if (pick < 42)
					it.w0 = OCR_READY_V2;
			end
			SEQ_CMD3: if (pick < 75) it.w0[12:9] = CUR_STATE_IDENT;
			SEQ_CMD7: if (pick < 75) it.w0[12:9] = CUR_STATE_STBY;
			SEQ_CMD9: begin
				if (pick < 45)
					it.w0[31:30] = CSD_V1;
				else if (pick < 90)
					it.w0[31:30] = CSD_V2;
			end
			default: ;
		endcase
		return it;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (quiet_sender)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------------------------------------------------------
	// Channel drivers (change on negedge, sample on posedge)
	// ---------------------------------------------------------------
	task automatic send_status(input status_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			status_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		status_ch.valid = 1'b1;
		status_ch.operation = it.op;
		status_ch.response_seen = it.seen;
		status_ch.timed_out = it.tmo;
		status_ch.crc_failed = it.crc;
		status_ch.sent_done = it.sent;
		status_ch.resp_word0 = it.w0;
		status_ch.resp_word1 = it.w1;
		status_ch.resp_word2 = it.w2;
		status_ch.resp_word3 = it.w3;
		do @(posedge clk); while (!status_ch.ready);
		predicted_cmds.push_back(advance_card(it));
		items_sent++;
	endtask

	// stop offering and let every owed command come out; one result per
	// item, so an empty queue plus the pipeline depth means the block is idle
	task automatic settle_idle();
		@(negedge clk);
		status_ch.valid = 1'b0;
		while (predicted_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_MAX_READY_TRIES)
			cfg_max_tries = val[7:0];
		else
			cfg_ocr_arg = val;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Command side: random stalls, plus the long hold on request
	// ---------------------------------------------------------------
	int stall_left = 0;

	always @(negedge clk) begin
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			command_ch.ready = 1'b0;
			stall_left--;
		end else if (!eager_sink && $urandom_range(99) < 20) begin
			command_ch.ready = 1'b0;
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 3);
			stall_left--;
		end else begin
			command_ch.ready = 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Result checker: every accepted command against the oldest prediction
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [32:0] want,
			input logic [32:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && command_ch.valid && command_ch.ready) begin
			if (predicted_cmds.size() == 0) begin
				$display("%0t: command item with nothing owed, expected none, got index %0d",
					$time, command_ch.cmd_index);
				mismatch_count++;
			end else begin
				want = predicted_cmds.pop_front();
				check_field("cmd_valid", want.cmd_valid, command_ch.cmd_valid);
				check_field("cmd_index", want.cmd_index, command_ch.cmd_index);
				check_field("cmd_argument", want.cmd_argument, command_ch.cmd_argument);
				check_field("expect_response", want.expect_response,
					command_ch.expect_response);
				check_field("long_response", want.long_response, command_ch.long_response);
				check_field("delay_first", want.delay_first, command_ch.delay_first);
				check_field("init_done", want.init_done, command_ch.init_done);
				check_field("init_failed", want.init_failed, command_ch.init_failed);
				check_field("card_version", want.card_version, command_ch.card_version);
				check_field("card_address", want.card_address, command_ch.card_address);
				check_field("block_count", want.block_count, command_ch.block_count);
				check_field("capacity_error", want.capacity_error,
					command_ch.capacity_error);
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if ((status_ch.valid && status_ch.ready) || (command_ch.valid && command_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d commands still owed",
					$time, stuck_cycles, predicted_cmds.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// completion before any start: nothing issued, reset state shown
	task automatic test_idle_completion();
		send_status(mk_done(1'b0, $urandom));
	endtask

	// full bring-up with default registers, touching every retry path
	task automatic test_full_bring_up();
		status_item_t it;
		send_status(mk_start());
		send_status(mk_done(1'b1, $urandom));          // CMD0 timeout ignored
		send_status(mk_done(1'b1, $urandom));          // CMD8 timeout ignored
		send_status(mk_done(1'b0, 32'h0));             // CMD55 -> ACMD41
		send_status(mk_done(1'b0, 32'h00ff8000));      // busy: retry w/ delay
		send_status(mk_done(1'b0, $urandom));          // CMD55
		send_status(mk_done(1'b1, OCR_READY_V2));      // ready word but timed out
		send_status(mk_done(1'b0, $urandom));          // CMD55
		send_status(mk_done(1'b0, OCR_READY_V1));      // v1 ready -> CMD2
		send_status(mk_done(1'b1, $urandom));          // CMD2 reissued
		send_status(mk_done(1'b0, $urandom));          // -> CMD3
		send_status(mk_done(1'b1, 32'hbeef_0400));     // CMD3 timeout, address not kept
		send_status(mk_done(1'b0, 32'hbeef_0600));     // wrong state
		send_status(mk_done(1'b0, 32'hffff_0400));     // ident, rca = 0xffff -> CMD9
		send_status(mk_done(1'b1, $urandom));          // CMD9 reissued
		// CSD v1, C_SIZE all ones, exponent sum 0: count shifts right
		it = mk_done(1'b0, 32'h0000_0000);
		it.w1 = 32'h0000_03ff;
		it.w2 = 32'hc000_0000;
		send_status(it);
		send_status(mk_done(1'b0, 32'h1234_0400));     // CMD7 wrong state
		send_status(mk_done(1'b1, 32'h1234_0600));     // CMD7 timeout
		send_status(mk_done(1'b0, 32'hffff_e7ff));     // stand-by, other bits set
		send_status(mk_done(1'b0, $urandom));          // CMD55 -> ACMD6
		send_status(mk_done(1'b1, $urandom));          // ACMD6 fail -> CMD55
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, $urandom));          // done
		send_status(mk_done(1'b0, $urandom));          // ignored after done
		settle_idle();
	endtask

	// try budget of one, ACMD41 argument all zero
	task automatic test_try_budget();
		write_reg(REG_MAX_READY_TRIES, 32'd1);
		write_reg(REG_READY_ARGUMENT, 32'h0);
		send_status(mk_start());
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, 32'h80ff8001));      // near miss -> failed
		send_status(mk_done(1'b0, OCR_READY_V1));      // ignored after failure
		settle_idle();
	endtask

	// widest budget, argument all ones, unknown CSD structure
	task automatic test_csd_fault();
		status_item_t it;
		write_reg(REG_MAX_READY_TRIES, 32'd255);
		write_reg(REG_READY_ARGUMENT, 32'hffff_ffff);
		send_status(mk_start());
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, OCR_READY_V2));
		send_status(mk_done(1'b0, $urandom));
		send_status(mk_done(1'b0, 32'h0000_0400));     // rca 0
		it = mk_done(1'b0, 32'hc000_0000 | 32'($urandom_range(32'h3fff_ffff)));
		send_status(it);                                // structure 3: count invalid
		settle_idle();
	endtask

	// command side held for a long stretch while items keep coming, so the
	// queue fills and status.ready drops; then the sender waits for all
	task automatic test_backpressure();
		int n;
		@(posedge clk);
		hold_request = 200;
		quiet_sender = 1'b1;
		send_status(mk_start());
		for (n = 0; n < 15; n++)
			send_status(shaped_completion());
		quiet_sender = 1'b0;
		settle_idle();
	endtask

	// one card session: start, then completions until done or failed,
	// with the odd restart and fully random item mixed in
	task automatic run_session();
		int steps;
		int pick;
		send_status(mk_start());
		steps = 0;
		while (seq_phase != SEQ_DONE && seq_phase != SEQ_FAILED && steps < 300) begin
			pick = $urandom_range(99);
			if (pick < 2)
				send_status(mk_start());
			else if (pick < 5)
				send_status(mk_done(1'($urandom), $urandom));
			else
				send_status(shaped_completion());
			steps++;
		end
		if ($urandom_range(1))
			send_status(shaped_completion());
	endtask

	task automatic test_random_sessions(input int target);
		int round;
		int stop_at;
		for (round = 0; round < 4; round++) begin
			settle_idle();
			case (round)
				0: write_reg(REG_MAX_READY_TRIES, 32'd3);
				1: write_reg(REG_MAX_READY_TRIES, 32'd255);
				default: write_reg(REG_MAX_READY_TRIES, 32'($urandom_range(1, 8)));
			endcase
			if (round == 3)
				write_reg(REG_READY_ARGUMENT, READY_ARGUMENT_RST);
			else
				write_reg(REG_READY_ARGUMENT, $urandom);
			// one round runs flat out on both sides
			quiet_sender = (round == 2);
			eager_sink = (round == 2);
			stop_at = items_sent + target / 4;
			while (items_sent < stop_at)
				run_session();
		end
		quiet_sender = 1'b0;
		eager_sink = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		status_ch.valid = 1'b0;
		status_ch.operation = OP_START;
		status_ch.response_seen = 1'b0;
		status_ch.timed_out = 1'b0;
		status_ch.crc_failed = 1'b0;
		status_ch.sent_done = 1'b0;
		status_ch.resp_word0 = '0;
		status_ch.resp_word1 = '0;
		status_ch.resp_word2 = '0;
		status_ch.resp_word3 = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MAX_READY_TRIES;
		cfg_ch.data = '0;
		command_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_completion();
		test_full_bring_up();
		test_try_budget();
		test_csd_fault();
		test_backpressure();
		test_random_sessions(RANDOM_ITEMS);

		// drain, then a few more cycles to catch any stray command item
		settle_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
sv/scis_pkg.sv
sv/scis_if.sv
sv/scis_front.sv
sv/scis_queue.sv
sv/scis_back.sv
sv/sd_card_init_sequencer_top.sv
bench/tb_top.sv
